FILE: hdl/scel_pkg.sv
// ----------------------------------------------------------------------------
// scel_pkg
// Shared types, register indexes and elaboration-time helpers used to build
// the softplus and sigmoid lookup tables of the cross-entropy loss block.
// ----------------------------------------------------------------------------
package scel_pkg;

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_IDX_SP = 9'b000000010,
    S_IDX_SG = 9'b000000100,
    S_XT     = 9'b000001000,
    S_LOSS   = 9'b000010000,
    S_ACC    = 9'b000100000,
    S_GRAD   = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  // configuration register indexes
  localparam logic REG_BATCH_COUNT    = 1'b0;
  localparam logic REG_GRADIENT_SCALE = 1'b1;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // restoring long division, evaluated only while building the tables
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b + (Q30_ONE >> 1);
    return p >> 30;
  endfunction

  // e^(-8/depth) in Q.30 from a truncated Taylor series
  function automatic logic [63:0] exp_step(input int unsigned depth);
    logic [63:0] s;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    s    = udiv64(64'd1 << 33, 64'(depth));
    term = Q30_ONE;
    pos  = Q30_ONE;
    neg  = '0;
    for (int k = 1; k <= 12; k++) begin
      term = udiv64((term * s) >> 30, 64'(k));
      if (k % 2 == 1) neg = neg + term;
      else            pos = pos + term;
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  // ln(1 + e) in Q.30 via the atanh series
  function automatic logic [63:0] ln1p_q30(input logic [63:0] e);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] sum;
    z   = udiv64(e << 30, (Q30_ONE << 1) + e);
    z2  = (z * z) >> 30;
    p   = z;
    sum = '0;
    for (int k = 1; k <= 25; k += 2) begin
      sum = sum + udiv64(p, 64'(k));
      p   = (p * z2) >> 30;
    end
    return sum << 1;
  endfunction

  // one table entry for the decay value e (Q2.30)
  function automatic logic [12:0] rom_entry(input logic [63:0] e, input logic is_sigmoid);
    logic [63:0] v;
    if (is_sigmoid)
      v = udiv64((64'd1 << 42) + ((Q30_ONE + e) >> 1), Q30_ONE + e);
    else
      v = (ln1p_q30(e) + (64'd1 << 17)) >> 18;
    return v[12:0];
  endfunction

endpackage

FILE: hdl/sigmoid_cross_entropy_loss.sv
// ----------------------------------------------------------------------------
// sigmoid_cross_entropy_loss
// Streaming sigmoid cross-entropy with logits: per-element scaled gradient and
// a per-batch mean loss, built around one shared multiplier and a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall) takes a logit (Q4.12), a target
//   (Q.12) and a batch_end flag. Output channel (result_valid / result_stall)
//   returns one word per input: gradient, plus mean_loss and loss_valid on
//   the last element of a batch, and loss_saturated on every word.
//   The config channel (cfg_valid / cfg_ready, always ready) writes
//   batch_count and gradient_scale; write only while the block is idle.
// Sequencing:
//   Each element steps through IDX_SP, IDX_SG, XT, LOSS, ACC, GRAD and FIN,
//   with DIV between GRAD and FIN when batch_end is set; the next element is
//   accepted only in IDLE. The single 17x25 multiplier is used four times per
//   element (two table index scalings, x*target, gradient scaling), and the
//   batch mean is a 32-step restoring divider, one quotient bit per cycle.
//   The result register holds a finished word while result_stall is high; the
//   sequencer waits in its last step until that register is free.
// Reset: rst (synchronous) clears the loss sum, the clip flag and the output
//   valid, and loads batch_count = 1, gradient_scale = 1.0. The tables are
//   constants, so no fill pass is needed.
// ----------------------------------------------------------------------------
module sigmoid_cross_entropy_loss
  import scel_pkg::*;
#(
  parameter int SOFTPLUS_TABLE_DEPTH = 256,
  parameter int SIGMOID_TABLE_DEPTH  = 256
) (
  input  logic               clk,
  input  logic               rst,
  // config
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data,
  // input words
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [15:0] logit,
  input  logic [12:0]        target,
  input  logic               batch_end,
  // result words
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [20:0] gradient,
  output logic [31:0]        mean_loss,
  output logic               loss_valid,
  output logic               loss_saturated
);

  localparam int SP_AW = $clog2(SOFTPLUS_TABLE_DEPTH);
  localparam int SG_AW = $clog2(SIGMOID_TABLE_DEPTH);
  localparam logic [13:0] SP_LAST = 14'(SOFTPLUS_TABLE_DEPTH - 1);
  localparam logic [13:0] SG_LAST = 14'(SIGMOID_TABLE_DEPTH - 1);
  localparam logic signed [24:0] SP_DEPTH_OP = 25'(SOFTPLUS_TABLE_DEPTH);
  localparam logic signed [24:0] SG_DEPTH_OP = 25'(SIGMOID_TABLE_DEPTH);

  typedef logic [12:0] sp_rom_t [SOFTPLUS_TABLE_DEPTH];
  typedef logic [12:0] sg_rom_t [SIGMOID_TABLE_DEPTH];

  function automatic sp_rom_t sp_fill();
    sp_rom_t     tab;
    logic [63:0] q;
    logic [63:0] e;
    q = exp_step(SOFTPLUS_TABLE_DEPTH);
    e = Q30_ONE;
    for (int i = 0; i < SOFTPLUS_TABLE_DEPTH; i++) begin
      tab[i] = rom_entry(e, 1'b0);
      e      = mul_q30(e, q);
    end
    return tab;
  endfunction

  function automatic sg_rom_t sg_fill();
    sg_rom_t     tab;
    logic [63:0] q;
    logic [63:0] e;
    q = exp_step(SIGMOID_TABLE_DEPTH);
    e = Q30_ONE;
    for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
      tab[i] = rom_entry(e, 1'b1);
      e      = mul_q30(e, q);
    end
    return tab;
  endfunction

  localparam sp_rom_t SP_ROM = sp_fill();
  localparam sg_rom_t SG_ROM = sg_fill();

  state_t state, state_next;

  // config registers
  logic [15:0]        batch_count;
  logic signed [23:0] gradient_scale;

  // element registers
  logic signed [15:0] x_r;
  logic [12:0]        t_r;
  logic               last_r;
  logic [15:0]        mag_r;
  logic [SP_AW-1:0]   sp_idx;
  logic [SG_AW-1:0]   sg_idx;
  logic [12:0]        sp_val;
  logic [12:0]        sg_val;
  logic signed [19:0] term;
  logic signed [20:0] grad_r;

  // batch state
  logic [31:0] loss_sum;
  logic        clip_seen;

  // divider
  logic [15:0] rem;
  logic [31:0] quo;
  logic [4:0]  div_cnt;

  // shared multiplier
  logic signed [16:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [41:0] prod;

  logic               out_free;
  logic [13:0]        idx_raw;
  logic [12:0]        sig;
  logic signed [13:0] diff;
  logic signed [31:0] term_wide;
  logic signed [31:0] term_rnd;
  logic signed [33:0] acc;
  logic signed [41:0] grad_rnd;
  logic signed [25:0] grad_sh;
  logic [15:0]        divisor;
  logic [16:0]        trial;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign out_free   = !result_valid || !result_stall;

  assign idx_raw = prod[28:15];
  assign sig     = x_r[15] ? 13'd4096 - sg_val : sg_val;
  assign diff    = $signed({1'b0, sig}) - $signed({1'b0, t_r});

  assign term_wide = $signed(x_r[15] ? 32'd0 : {5'd0, x_r[14:0], 12'd0})
                   + $signed({7'd0, sp_val, 12'd0}) - prod[31:0];
  assign term_rnd  = term_wide + 32'sd2048;

  assign acc = $signed({2'b00, loss_sum}) + $signed({{14{term[19]}}, term});

  assign grad_rnd = prod + 42'sd32768;
  assign grad_sh  = grad_rnd[41:16];

  assign divisor = (batch_count == 16'd0) ? 16'd1 : batch_count;
  assign trial   = {rem, quo[31]};

  always_comb begin
    unique case (state)
      S_IDX_SP: begin
        mul_a = $signed({1'b0, mag_r});
        mul_b = SP_DEPTH_OP;
      end
      S_IDX_SG: begin
        mul_a = $signed({1'b0, mag_r});
        mul_b = SG_DEPTH_OP;
      end
      S_XT: begin
        mul_a = $signed({x_r[15], x_r});
        mul_b = $signed({12'd0, t_r});
      end
      S_ACC: begin
        mul_a = $signed({{3{diff[13]}}, diff});
        mul_b = $signed({gradient_scale[23], gradient_scale});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (item_valid) state_next = S_IDX_SP;
      S_IDX_SP: state_next = S_IDX_SG;
      S_IDX_SG: state_next = S_XT;
      S_XT:     state_next = S_LOSS;
      S_LOSS:   state_next = S_ACC;
      S_ACC:    state_next = S_GRAD;
      S_GRAD:   state_next = last_r ? S_DIV : S_FIN;
      S_DIV:    if (div_cnt == 5'd31) state_next = S_FIN;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // table reads, registered
  always_ff @(posedge clk) begin
    sp_val <= SP_ROM[sp_idx];
    sg_val <= SG_ROM[sg_idx];
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      S_IDLE: begin
        x_r    <= logit;
        t_r    <= target;
        last_r <= batch_end;
        mag_r  <= logit[15] ? 16'(-logit) : logit;
      end
      S_IDX_SG: sp_idx <= (idx_raw > SP_LAST) ? SP_LAST[SP_AW-1:0] : idx_raw[SP_AW-1:0];
      S_XT:     sg_idx <= (idx_raw > SG_LAST) ? SG_LAST[SG_AW-1:0] : idx_raw[SG_AW-1:0];
      S_LOSS:   term   <= term_rnd[31:12];
      S_GRAD: begin
        if (grad_sh > 26'sd1048575)
          grad_r <= 21'sd1048575;
        else if (grad_sh < -26'sd1048576)
          grad_r <= -21'sd1048576;
        else
          grad_r <= grad_sh[20:0];
        rem     <= '0;
        div_cnt <= '0;
        // quotient is already in quo when the batch sum is cleared
        quo     <= loss_sum;
      end
      S_DIV: begin
        // one quotient bit per cycle
        if (trial >= {1'b0, divisor}) begin
          rem <= 16'(trial - {1'b0, divisor});
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= trial[15:0];
          quo <= {quo[30:0], 1'b0};
        end
        div_cnt <= div_cnt + 5'd1;
      end
      default: ;
    endcase
    if (state == S_FIN && out_free) begin
      gradient       <= grad_r;
      mean_loss      <= last_r ? quo : 32'd0;
      loss_valid     <= last_r;
      loss_saturated <= clip_seen;
    end
  end

  // control, config and batch state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      result_valid   <= 1'b0;
      loss_sum       <= '0;
      clip_seen      <= 1'b0;
      batch_count    <= 16'd1;
      gradient_scale <= 24'sd65536;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_BATCH_COUNT:    batch_count    <= cfg_data[15:0];
          REG_GRADIENT_SCALE: gradient_scale <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_ACC) begin
        if (acc[33]) begin
          loss_sum  <= '0;
          clip_seen <= 1'b1;
        end else if (acc[32]) begin
          loss_sum  <= '1;
          clip_seen <= 1'b1;
        end else begin
          loss_sum <= acc[31:0];
        end
      end
      if (state == S_FIN && out_free) begin
        result_valid <= 1'b1;
        if (last_r) begin
          loss_sum  <= '0;
          clip_seen <= 1'b0;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
